// ===== sv/chunked_body_decoder_defines.svh =====
// Assertion macros shared by the chunked body decoder RTL.
`ifndef CHUNKED_BODY_DECODER_DEFINES_SVH
`define CHUNKED_BODY_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that a condition implies a consequence in the same cycle.
`define CBD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chunked body decoder: same-cycle check failed");
// Checks that a condition implies a consequence in the next cycle.
`define CBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chunked body decoder: next-cycle check failed");
// Checks a consequence in the cycle after reset, reset included.
`define CBD_ASSERT_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("chunked body decoder: reset check failed");
`else
`define CBD_ASSERT_NOW(label, ante, cons)
`define CBD_ASSERT_NEXT(label, ante, cons)
`define CBD_ASSERT_RESET(label, cons)
`endif
`endif

// ===== sv/cbd_pkg.sv =====
// Types, constants and helper functions of the chunked body decoder.
package cbd_pkg;

   // Width of the size, remaining and total length counters.
   localparam int LEN_W = 32;
   // Width of the limit register and of the reported total.
   localparam int LIMIT_W = 32;
   localparam int SUM_W = ((LEN_W > LIMIT_W) ? LEN_W : LIMIT_W) + 1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_HT   = 8'h09;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_BAD  = 2'd2,
      KIND_BIG  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      PH_LEAD      = 4'd0,
      PH_HEX       = 4'd1,
      PH_TAIL      = 4'd2,
      PH_EXT       = 4'd3,
      PH_LINE_LF   = 4'd4,
      PH_DATA      = 4'd5,
      PH_DATA_CR   = 4'd6,
      PH_DATA_LF   = 4'd7,
      PH_END_FIRST = 4'd8,
      PH_END_LF    = 4'd9,
      PH_TRAILER   = 4'd10
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   // Decodes one ASCII hex digit in either case.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         h.value = 4'(c - 8'h30);
      end else if (c inside {[8'h41:8'h46]}) begin
         h.value = 4'(c - 8'h41 + 8'd10);
      end else if (c inside {[8'h61:8'h66]}) begin
         h.value = 4'(c - 8'h61 + 8'd10);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== sv/cbd_req_if.sv =====
// Request channel carrying raw body bytes into the decoder.
interface cbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/cbd_rsp_if.sv =====
// Result channel carrying decoded bytes and body status out of the decoder.
interface cbd_rsp_if;
   logic                          valid;
   logic                          ready;
   cbd_pkg::kind_type             kind;
   logic [7:0]                    out_byte;
   logic [cbd_pkg::LIMIT_W-1:0]   total_length;

   modport source (output valid, output kind, output out_byte, output total_length,
                   input ready);
   modport sink   (input valid, input kind, input out_byte, input total_length,
                   output ready);
endinterface

// ===== sv/chunked_body_decoder.sv =====
// Top level of the chunked transfer body decoder.
//
//   channel   direction  payload                         handshake
//   req_if    in         in_byte                         valid/ready
//   rsp_if    out        kind, out_byte, total_length    valid/ready
//   csr_*     in         max_body_bytes                  csr_wr_en, no wait
//
// For each accepted request the parser state updates at the accepting edge and any
// result lands in the output register at that same edge, so one byte per cycle is
// sustained while results are taken. Reset is synchronous and active high; it
// clears the parser and loads the limit with 1048576. A held result only stalls
// requests when it is not taken in the cycle a new request would replace it.
`include "chunked_body_decoder_defines.svh"

module chunked_body_decoder (
   input  logic                        clock,
   input  logic                        reset,
   cbd_req_if.sink                     req_if,
   cbd_rsp_if.source                   rsp_if,
   input  logic                        csr_wr_en,
   input  logic [cbd_pkg::LIMIT_W-1:0] csr_wr_data
);
   import cbd_pkg::*;

   phase_type          phase_ff,   phase_in;
   logic [LEN_W-1:0]   size_ff,    size_in;
   logic [LEN_W-1:0]   left_ff,    left_in;
   logic [LEN_W-1:0]   total_ff,   total_in;
   logic               digit_ff,   digit_in;
   logic [1:0]         match_ff,   match_in;
   logic [LIMIT_W-1:0] limit_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff;
   logic [7:0]         byte_ff;
   logic [LIMIT_W-1:0] length_ff;

   logic               accept;
   logic               emit;
   kind_type           emit_kind;
   logic               rearm;
   logic [7:0]         c;
   hex_type            hex;
   logic               blank;
   logic [SUM_W-1:0]   need_sum;
   logic               too_big;
   logic [1:0]         trailer_next;
   logic [7:0]         trailer_want;

   // A new request is taken whenever the output register is free or being drained.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign c     = req_if.in_byte;
   assign hex   = hex_decode(c);
   assign blank = (c == CH_SP) || (c == CH_HT);

   // Limit check at the end of a size line: total plus new chunk against the limit.
   assign need_sum = SUM_W'(total_ff) + SUM_W'(size_ff);
   assign too_big  = need_sum > SUM_W'(limit_ff);

   // Trailer scan for CR LF CR LF; even positions expect CR, odd ones LF.
   assign trailer_want = match_ff[0] ? CH_LF : CH_CR;
   assign trailer_next = (c == trailer_want) ? 2'(match_ff + 2'd1)
                                             : ((c == CH_CR) ? 2'd1 : 2'd0);

   // Parser next state and result for the byte on the request channel.
   always_comb begin
      phase_in  = phase_ff;
      size_in   = size_ff;
      left_in   = left_ff;
      total_in  = total_ff;
      digit_in  = digit_ff;
      match_in  = match_ff;
      emit      = 1'b0;
      emit_kind = KIND_DATA;
      rearm     = 1'b0;
      case (phase_ff)
         PH_LEAD, PH_HEX: begin
            if (hex.valid) begin
               if (size_ff[LEN_W-1 -: 4] != 4'd0) begin
                  emit      = 1'b1;
                  emit_kind = KIND_BIG;
               end else begin
                  size_in  = {size_ff[LEN_W-5:0], hex.value};
                  digit_in = 1'b1;
                  phase_in = PH_HEX;
               end
            end else if (blank) begin
               if (phase_ff == PH_HEX) phase_in = PH_TAIL;
            end else if (c == CH_SEMI) begin
               phase_in = PH_EXT;
            end else if (c == CH_CR) begin
               phase_in = PH_LINE_LF;
            end else begin
               emit      = 1'b1;
               emit_kind = KIND_BAD;
            end
         end
         PH_TAIL: begin
            if (c == CH_SEMI) begin
               phase_in = PH_EXT;
            end else if (c == CH_CR) begin
               phase_in = PH_LINE_LF;
            end else if (!blank) begin
               emit      = 1'b1;
               emit_kind = KIND_BAD;
            end
         end
         PH_EXT: begin
            if (c == CH_CR) phase_in = PH_LINE_LF;
         end
         PH_LINE_LF: begin
            if (c != CH_LF || !digit_ff) begin
               emit      = 1'b1;
               emit_kind = KIND_BAD;
            end else if (size_ff == '0) begin
               phase_in = PH_END_FIRST;
            end else if (too_big) begin
               emit      = 1'b1;
               emit_kind = KIND_BIG;
            end else begin
               left_in  = size_ff;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            total_in  = total_ff + LEN_W'(1);
            left_in   = left_ff - LEN_W'(1);
            emit      = 1'b1;
            emit_kind = KIND_DATA;
            if (left_ff == LEN_W'(1)) phase_in = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (c != CH_CR) begin
               emit      = 1'b1;
               emit_kind = KIND_BAD;
            end else begin
               phase_in = PH_DATA_LF;
            end
         end
         PH_DATA_LF: begin
            if (c != CH_LF) begin
               emit      = 1'b1;
               emit_kind = KIND_BAD;
            end else begin
               phase_in = PH_LEAD;
               size_in  = '0;
               digit_in = 1'b0;
            end
         end
         PH_END_FIRST: begin
            if (c == CH_CR) begin
               phase_in = PH_END_LF;
            end else begin
               phase_in = PH_TRAILER;
               match_in = 2'd0;
            end
         end
         PH_END_LF: begin
            if (c == CH_LF) begin
               emit      = 1'b1;
               emit_kind = KIND_DONE;
            end else begin
               phase_in = PH_TRAILER;
               match_in = (c == CH_CR) ? 2'd1 : 2'd0;
            end
         end
         PH_TRAILER: begin
            if (match_ff == 2'd3 && c == CH_LF) begin
               emit      = 1'b1;
               emit_kind = KIND_DONE;
            end else begin
               match_in = trailer_next;
            end
         end
         default: begin
            rearm = 1'b1;
         end
      endcase
      // Any status result ends the body and rearms the parser.
      if (rearm || (emit && emit_kind != KIND_DATA)) begin
         phase_in = PH_LEAD;
         size_in  = '0;
         left_in  = '0;
         total_in = '0;
         digit_in = 1'b0;
         match_in = 2'd0;
      end
   end

   // Parser state advances only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         size_ff  <= '0;
         left_ff  <= '0;
         total_ff <= '0;
         digit_ff <= 1'b0;
         match_ff <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         size_ff  <= size_in;
         left_ff  <= left_in;
         total_ff <= total_in;
         digit_ff <= digit_in;
         match_ff <= match_in;
      end
   end

   // Limit register written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Output register: filled by an accepted request with a result, emptied when taken.
   assign rsp_valid_in = accept ? emit : (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff   <= emit_kind;
         byte_ff   <= (emit_kind == KIND_DATA) ? c : 8'd0;
         length_ff <= (emit_kind == KIND_DONE) ? LIMIT_W'(total_ff) : '0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = kind_ff;
   assign rsp_if.out_byte     = byte_ff;
   assign rsp_if.total_length = length_ff;

   // Consistency checks on the parser and the output register.
   `CBD_ASSERT_RESET(a_reset_phase, phase_ff == PH_LEAD && rsp_valid_ff == 1'b0)
   `CBD_ASSERT_NEXT(a_data_passes, accept && phase_ff == PH_DATA,
                    rsp_valid_ff && kind_ff == KIND_DATA)
   `CBD_ASSERT_NEXT(a_status_rearms, accept && emit && emit_kind != KIND_DATA,
                    phase_ff == PH_LEAD && total_ff == '0 && size_ff == '0)
   `CBD_ASSERT_NOW(a_hold_blocks, rsp_valid_ff && !rsp_if.ready, !req_if.ready)

endmodule

// ===== sim/tb_chunked_body_decoder.sv =====
// Self-checking testbench for the chunked body decoder: directed and random bodies, checked in order.
module tb_chunked_body_decoder;
   import cbd_pkg::*;

   // Tracks the decoder's parse state and holds the results it should produce.
   class chunk_decode_predictor;
      typedef struct {
         kind_type           kind;
         logic [7:0]         data;
         logic [LIMIT_W-1:0] length;
      } decoded_item_type;

      decoded_item_type   awaited[$];
      logic [LIMIT_W-1:0] limit;
      phase_type          phase;
      logic [LEN_W-1:0]   size_acc;
      logic [LEN_W-1:0]   data_left;
      logic [LEN_W-1:0]   total;
      bit                 digit_seen;
      int unsigned        trail_hits;
      int unsigned        errors;

      function new();
         limit = LIMIT_RESET;
         errors = 0;
         rearm();
      endfunction

      // Returns to the start of a fresh body.
      function void rearm();
         phase = PH_LEAD;
         size_acc = '0;
         data_left = '0;
         total = '0;
         digit_seen = 1'b0;
         trail_hits = 0;
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
         if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
         if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
         return -1;
      endfunction

      // Any result other than a data byte ends the body.
      function void push_result(kind_type k, logic [7:0] d, logic [LIMIT_W-1:0] len);
         decoded_item_type item;
         item.kind = k;
         item.data = d;
         item.length = len;
         awaited.push_back(item);
         if (k != KIND_DATA) rearm();
      endfunction

      // A complete size line: empty, last chunk, over the limit, or a payload to follow.
      function void close_size_line();
         if (!digit_seen) begin
            push_result(KIND_BAD, 8'd0, '0);
         end else if (size_acc == '0) begin
            phase = PH_END_FIRST;
         end else if (64'(total) + 64'(size_acc) > 64'(limit)) begin
            push_result(KIND_BIG, 8'd0, '0);
         end else begin
            data_left = size_acc;
            phase = PH_DATA;
         end
      endfunction

      // Advances the parser by one accepted request byte.
      function void predict_byte(logic [7:0] c);
         int          hv;
         bit          blank;
         int unsigned m;
         hv = hex_digit(c);
         blank = (c == CH_SP) || (c == CH_HT);
         case (phase)
            PH_LEAD, PH_HEX: begin
               if (hv >= 0) begin
                  if (size_acc[LEN_W-1 -: 4] != 4'd0) begin
                     push_result(KIND_BIG, 8'd0, '0);
                  end else begin
                     size_acc = {size_acc[LEN_W-5:0], 4'(hv)};
                     digit_seen = 1'b1;
                     phase = PH_HEX;
                  end
               end else if (blank) begin
                  if (phase == PH_HEX) phase = PH_TAIL;
               end else if (c == CH_SEMI) begin
                  phase = PH_EXT;
               end else if (c == CH_CR) begin
                  phase = PH_LINE_LF;
               end else begin
                  push_result(KIND_BAD, 8'd0, '0);
               end
            end
            PH_TAIL: begin
               if (c == CH_SEMI) phase = PH_EXT;
               else if (c == CH_CR) phase = PH_LINE_LF;
               else if (!blank) push_result(KIND_BAD, 8'd0, '0);
            end
            PH_EXT: begin
               if (c == CH_CR) phase = PH_LINE_LF;
            end
            PH_LINE_LF: begin
               if (c != CH_LF) push_result(KIND_BAD, 8'd0, '0);
               else close_size_line();
            end
            PH_DATA: begin
               total = total + 1'b1;
               data_left = data_left - 1'b1;
               if (data_left == '0) phase = PH_DATA_CR;
               push_result(KIND_DATA, c, '0);
            end
            PH_DATA_CR: begin
               if (c != CH_CR) push_result(KIND_BAD, 8'd0, '0);
               else phase = PH_DATA_LF;
            end
            PH_DATA_LF: begin
               if (c != CH_LF) begin
                  push_result(KIND_BAD, 8'd0, '0);
               end else begin
                  phase = PH_LEAD;
                  size_acc = '0;
                  digit_seen = 1'b0;
               end
            end
            PH_END_FIRST: begin
               if (c == CH_CR) begin
                  phase = PH_END_LF;
               end else begin
                  phase = PH_TRAILER;
                  trail_hits = 0;
               end
            end
            PH_END_LF: begin
               if (c == CH_LF) begin
                  push_result(KIND_DONE, 8'd0, LIMIT_W'(total));
               end else begin
                  phase = PH_TRAILER;
                  trail_hits = (c == CH_CR) ? 1 : 0;
               end
            end
            PH_TRAILER: begin
               // The closing pattern alternates CR and LF.
               if (c == ((trail_hits % 2 == 0) ? CH_CR : CH_LF)) m = trail_hits + 1;
               else m = (c == CH_CR) ? 1 : 0;
               if (m >= 4) push_result(KIND_DONE, 8'd0, LIMIT_W'(total));
               else trail_hits = m;
            end
            default: begin
               rearm();
            end
         endcase
      endfunction

      // Compares one accepted result with the oldest expectation.
      function void check_result(kind_type k, logic [7:0] d, logic [LIMIT_W-1:0] len);
         decoded_item_type want;
         if (awaited.size() == 0) begin
            $error("result with none expected: kind %0d, out_byte %0d, total_length %0d",
                   k, d, len);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (k !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, k);
            errors++;
         end
         if (d !== want.data) begin
            $error("out_byte: expected %0d, actual %0d", want.data, d);
            errors++;
         end
         if (len !== want.length) begin
            $error("total_length: expected %0d, actual %0d", want.length, len);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   localparam int QUIET_LIMIT = 2000;

   // Error cases run right after reset, one group per case.
   localparam logic [7:0] OPENING [24] = '{
      CH_CR, CH_LF,                              // empty size line
      "g",                                       // character outside the grammar
      CH_LF,                                     // bare LF
      "1", " ", "2",                             // digit after trailing space
      "1", CH_CR, "X",                           // CR without LF
      "1", CH_CR, CH_LF, "A", "X",               // chunk not closed by CR LF
      "1", "2", "3", "4", "5", "6", "7", "8", "9" // size wider than the counter
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [LIMIT_W-1:0]   csr_wr_data;
   bit                   calm;
   int unsigned          sent;
   int unsigned          stall_left;
   int unsigned          quiet;
   logic [7:0]           body_bytes[$];
   chunk_decode_predictor sb;

   cbd_req_if req ();
   cbd_rsp_if rsp ();

   chunked_body_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req),
      .rsp_if      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Presents one request byte, after an optional idle burst, and waits until it is taken.
   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.in_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.predict_byte(b);
      sent++;
   endtask

   task automatic send_queued();
      foreach (body_bytes[i]) send_byte(body_bytes[i]);
   endtask

   function automatic logic [7:0] field_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
      return b;
   endfunction

   // Appends a size line with random padding, case, leading zero and extension.
   function automatic void add_size_line(int unsigned len);
      bit         started;
      int         sh;
      logic [3:0] nib;
      logic [7:0] b;
      started = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
         body_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
      if ($urandom_range(0, 4) == 0) body_bytes.push_back("0");
      for (sh = 28; sh >= 0; sh -= 4) begin
         nib = 4'(len >> sh);
         if (nib != 4'd0 || started || sh == 0) begin
            started = 1'b1;
            if (nib < 4'd10) body_bytes.push_back(8'h30 + 8'(nib));
            else if ($urandom_range(0, 1)) body_bytes.push_back(8'h41 + 8'(nib) - 8'd10);
            else body_bytes.push_back(8'h61 + 8'(nib) - 8'd10);
         end
      end
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
         body_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
      if ($urandom_range(0, 3) == 0) begin
         body_bytes.push_back(CH_SEMI);
         repeat ($urandom_range(0, 5)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
            body_bytes.push_back(b);
         end
      end
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(CH_LF);
   endfunction

   // Builds a well-formed body with random chunks and ending; a rough body may be
   // damaged or cut short.
   task automatic send_body(input bit rough);
      int         nchunks;
      int         len;
      int         k;
      int         pos;
      logic [7:0] b;
      body_bytes.delete();
      nchunks = $urandom_range(0, 3);
      for (k = 0; k < nchunks; k++) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         add_size_line(len);
         repeat (len) body_bytes.push_back(8'($urandom_range(0, 255)));
         body_bytes.push_back(CH_CR);
         body_bytes.push_back(CH_LF);
      end
      add_size_line(0);
      case ($urandom_range(0, 3))
         0, 1: begin
            body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
         end
         2: begin
            // Trailer header lines, then the empty line.
            repeat ($urandom_range(1, 2)) begin
               repeat ($urandom_range(1, 6)) body_bytes.push_back(field_byte());
               body_bytes.push_back(CH_CR);
               body_bytes.push_back(CH_LF);
            end
            body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
         end
         default: begin
            // A CR right after the last size line that is not followed by LF.
            body_bytes.push_back(CH_CR);
            if ($urandom_range(0, 1)) body_bytes.push_back(field_byte());
            body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
            body_bytes.push_back(CH_CR);
            body_bytes.push_back(CH_LF);
         end
      endcase
      if (rough && $urandom_range(0, 3) == 0) begin
         pos = $urandom_range(0, body_bytes.size() - 1);
         if ($urandom_range(0, 1)) begin
            do b = 8'($urandom_range(0, 255)); while (sb.hex_digit(b) >= 0);
            body_bytes[pos] = b;
         end else begin
            while (body_bytes.size() > pos + 1) void'(body_bytes.pop_back());
         end
      end
      send_queued();
   endtask

   // Steers the parser back to the start of a fresh body.
   task automatic resync();
      while (!(sb.phase == PH_LEAD && sb.total == '0)) begin
         case (sb.phase)
            PH_EXT:     send_byte(CH_CR);
            PH_TRAILER: send_byte((sb.trail_hits % 2 == 1) ? CH_LF : CH_CR);
            PH_DATA:    send_byte(8'($urandom_range(0, 255)));
            default:    send_byte("Z");
         endcase
      end
   endtask

   task automatic run_bodies(input int unsigned upto, input bit rough);
      while (sent < upto) begin
         resync();
         if (rough && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_body(rough);
         end
      end
   endtask

   // Stops requests and waits until every expected result has been taken.
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.limit = value;
   endtask

   // Result side: check each taken result, stall in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            sb.check_result(rsp.kind, rsp.out_byte, rsp.total_length);
         end
         if (calm) begin
            rsp.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.in_byte = 8'd0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      calm = 1'b0;
      sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Error cases at the reset limit.
      foreach (OPENING[i]) send_byte(OPENING[i]);

      // Widest limit: clean bodies only, so sizes stay small.
      write_limit('1);
      run_bodies(250, 1'b0);

      // Zero limit: every nonzero chunk is too large.
      write_limit('0);
      run_bodies(350, 1'b1);

      write_limit(LIMIT_W'(40));
      run_bodies(650, 1'b1);

      // Lower the limit below the running total in the middle of a body.
      write_limit(LIMIT_W'(1000));
      resync();
      body_bytes.delete();
      add_size_line(30);
      repeat (30) body_bytes.push_back(8'($urandom_range(0, 255)));
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(CH_LF);
      send_queued();
      write_limit(LIMIT_W'(10));
      body_bytes.delete();
      add_size_line(1);
      send_queued();
      run_bodies(900, 1'b1);

      // Last stretch at full rate on both sides.
      write_limit(LIMIT_W'(100));
      calm = 1'b1;
      run_bodies(1150, 1'b1);

      drain();
      repeat (5) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+sv
sv/cbd_pkg.sv
sv/cbd_req_if.sv
sv/cbd_rsp_if.sv
sv/chunked_body_decoder.sv
sim/tb_chunked_body_decoder.sv
